// ----- hdl/agm_pkg.sv -----
// Shared types and default sizes for the anagram group matcher.
// No dependencies; used by every module of the block.
package agm_pkg;

    localparam int AlphabetSizeDef = 26;
    localparam int MaxLengthDef    = 128;
    localparam int GroupEntriesDef = 64;
    localparam int CountW          = 8;
    localparam int LetterW         = 5;
    localparam int GroupIdxW       = 6;

    // Control bits that travel with a query down the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
        logic too_long;
    } t_qctl;

endpackage

// ----- hdl/anagram_group_matcher.sv -----
// Top level of the anagram group matcher: histogram stage, chain of table cells,
// allocation and result register. Depends on agm_pkg, agm_hist and agm_cell.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-------------------------------------------------
//  input   | i_valid  | o_stall  | i_letter, i_has_letter, i_end_of_string
//  result  | o_valid  | i_stall  | o_group_index, o_new_group, o_table_full, o_too_long
//
// Letters without an end mark take one cycle each, back to back.
// A string end sends its histogram down GROUP_ENTRIES cells, one cell per cycle,
// and the result register takes its result as it leaves the last cell.
// Input stays stalled from the end beat until that result beat is taken.
// Reset clears the histogram, all entry valid bits and the used count at once.
module anagram_group_matcher import agm_pkg::*; #(
    parameter int ALPHABET_SIZE = AlphabetSizeDef,
    parameter int MAX_LENGTH    = MaxLengthDef,
    parameter int GROUP_ENTRIES = GroupEntriesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [LetterW-1:0]   i_letter,
    input  logic                 i_has_letter,
    input  logic                 i_end_of_string,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [GroupIdxW-1:0] o_group_index,
    output logic                 o_new_group,
    output logic                 o_table_full,
    output logic                 o_too_long
);

    localparam int IdxW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int HistW = ALPHABET_SIZE * CountW;

    t_qctl             q    [GROUP_ENTRIES+1];
    logic [IdxW-1:0]   qidx [GROUP_ENTRIES+1];
    logic [HistW-1:0]  qhist[GROUP_ENTRIES+1];
    logic [GROUP_ENTRIES:0] qvalid;

    logic              in_acc, out_acc;
    logic              r_busy;
    logic [IdxW:0]     r_used;
    logic              wr_en;
    logic              r_valid;
    logic [IdxW-1:0]   r_idx;
    logic              r_new, r_full, r_long;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_valid && !i_stall;
    assign o_stall = r_busy;

    agm_hist #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_hist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_letter       (i_letter),
        .i_has_letter   (i_has_letter),
        .i_end_of_string(i_end_of_string),
        .o_q            (q[0]),
        .o_hist         (qhist[0])
    );
    assign qidx[0] = '0;

    for (genvar g = 0; g < GROUP_ENTRIES; g++) begin : g_cell
        agm_cell #(
            .ALPHABET_SIZE(ALPHABET_SIZE),
            .IDX_W        (IdxW),
            .INDEX        (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_q      (q[g]),
            .i_idx    (qidx[g]),
            .i_hist   (qhist[g]),
            .i_wr_en  (wr_en),
            .i_wr_idx (r_used[IdxW-1:0]),
            .i_wr_hist(qhist[GROUP_ENTRIES]),
            .o_q      (q[g+1]),
            .o_idx    (qidx[g+1]),
            .o_hist   (qhist[g+1])
        );
    end

    for (genvar g = 0; g <= GROUP_ENTRIES; g++) begin : g_qv
        assign qvalid[g] = q[g].valid;
    end

    // A query leaving the chain unmatched takes the next free entry, if the table has one.
    assign wr_en = q[GROUP_ENTRIES].valid && !q[GROUP_ENTRIES].found
                   && (r_used < (IdxW+1)'(GROUP_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_acc && i_end_of_string) begin
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_busy <= 1'b0;
            end
            if (wr_en) begin
                r_used <= r_used + 1'b1;
            end
            if (q[GROUP_ENTRIES].valid) begin
                r_valid <= 1'b1;
            end else if (out_acc) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q[GROUP_ENTRIES].valid) begin
            r_long <= q[GROUP_ENTRIES].too_long;
            r_new  <= wr_en;
            r_full <= !q[GROUP_ENTRIES].found && !wr_en;
            priority if (q[GROUP_ENTRIES].found) begin
                r_idx <= qidx[GROUP_ENTRIES];
            end else if (wr_en) begin
                r_idx <= r_used[IdxW-1:0];
            end else begin
                r_idx <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_group_index = GroupIdxW'(r_idx);
    assign o_new_group   = r_new;
    assign o_table_full  = r_full;
    assign o_too_long    = r_long;

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_busy)
        else $error("result held while input side not busy");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (IdxW+1)'(GROUP_ENTRIES))
        else $error("entry count past table size");

    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(qvalid) <= 1)
        else $error("more than one query in the chain");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_new && r_full))
        else $error("new group and table full together");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q[GROUP_ENTRIES].valid |-> !r_valid)
        else $error("query arrived while a result is pending");

endmodule

// ----- hdl/agm_hist.sv -----
// Letter histogram of the string in progress; launches a query into the chain.
// Depends on agm_pkg.
module agm_hist import agm_pkg::*; #(
    parameter int ALPHABET_SIZE = AlphabetSizeDef,
    parameter int MAX_LENGTH    = MaxLengthDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [LetterW-1:0]                i_letter,
    input  logic                              i_has_letter,
    input  logic                              i_end_of_string,
    output t_qctl                             o_q,
    output logic [ALPHABET_SIZE*CountW-1:0]   o_hist
);

    logic [ALPHABET_SIZE*CountW-1:0] r_counts, n_counts;
    logic [CountW-1:0]               r_len, n_len;
    logic                            r_long, n_long;
    logic                            in_alpha, room;
    t_qctl                           r_q;
    logic [ALPHABET_SIZE*CountW-1:0] r_hist;

    assign in_alpha = i_has_letter && ({2'b00, i_letter} < 7'(ALPHABET_SIZE));
    assign room     = r_len < CountW'(MAX_LENGTH);

    always_comb begin
        n_counts = r_counts;
        n_len    = r_len;
        n_long   = r_long;
        if (in_alpha) begin
            if (room) begin
                for (int k = 0; k < ALPHABET_SIZE; k++) begin
                    if ({2'b00, i_letter} == 7'(k)) begin
                        n_counts[k*CountW +: CountW] = r_counts[k*CountW +: CountW] + 1'b1;
                    end
                end
                n_len = r_len + 1'b1;
            end else begin
                n_long = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
            r_len    <= '0;
            r_long   <= 1'b0;
            r_q      <= '0;
        end else begin
            r_q.valid    <= i_accept && i_end_of_string;
            r_q.found    <= 1'b0;
            r_q.too_long <= n_long;
            if (i_accept) begin
                if (i_end_of_string) begin
                    r_counts <= '0;
                    r_len    <= '0;
                    r_long   <= 1'b0;
                end else begin
                    r_counts <= n_counts;
                    r_len    <= n_len;
                    r_long   <= n_long;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist <= n_counts;
    end

    assign o_q    = r_q;
    assign o_hist = r_hist;

endmodule

// ----- hdl/agm_cell.sv -----
// One signature table entry: holds a stored histogram and checks the passing query.
// Depends on agm_pkg.
module agm_cell import agm_pkg::*; #(
    parameter int ALPHABET_SIZE = AlphabetSizeDef,
    parameter int IDX_W         = 6,
    parameter int INDEX         = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_qctl                           i_q,
    input  logic [IDX_W-1:0]                i_idx,
    input  logic [ALPHABET_SIZE*CountW-1:0] i_hist,
    input  logic                            i_wr_en,
    input  logic [IDX_W-1:0]                i_wr_idx,
    input  logic [ALPHABET_SIZE*CountW-1:0] i_wr_hist,
    output t_qctl                           o_q,
    output logic [IDX_W-1:0]                o_idx,
    output logic [ALPHABET_SIZE*CountW-1:0] o_hist
);

    logic                            r_valid;
    logic [ALPHABET_SIZE*CountW-1:0] r_sig;
    t_qctl                           r_q;
    logic [IDX_W-1:0]                r_idx;
    logic [ALPHABET_SIZE*CountW-1:0] r_hist;
    logic                            hit, wr_here;

    assign hit     = i_q.valid && !i_q.found && r_valid && (r_sig == i_hist);
    assign wr_here = i_wr_en && (i_wr_idx == IDX_W'(INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_q     <= '0;
        end else begin
            if (wr_here) begin
                r_valid <= 1'b1;
            end
            r_q <= {i_q.valid, i_q.found || hit, i_q.too_long};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_sig <= i_wr_hist;
        end
        r_idx  <= hit ? IDX_W'(INDEX) : i_idx;
        r_hist <= i_hist;
    end

    assign o_q    = r_q;
    assign o_idx  = r_idx;
    assign o_hist = r_hist;

endmodule
